>>> src/alu8_pkg.sv
// ----------------------------------------------------------------------------
// alu8_pkg
// Types and constants shared by the eight-bit ALU and its core.
// ----------------------------------------------------------------------------
`default_nettype none

package alu8_pkg;

  typedef enum logic [4:0] {
    MODE_ADD      = 5'd0,
    MODE_ADC      = 5'd1,
    MODE_SUB      = 5'd2,
    MODE_SBC      = 5'd3,
    MODE_AND      = 5'd4,
    MODE_XOR      = 5'd5,
    MODE_OR       = 5'd6,
    MODE_CP       = 5'd7,
    MODE_INC      = 5'd8,
    MODE_DEC      = 5'd9,
    MODE_DAA      = 5'd10,
    MODE_CPL      = 5'd11,
    MODE_SCF      = 5'd12,
    MODE_CCF      = 5'd13,
    MODE_RLCA     = 5'd14,
    MODE_RLA      = 5'd15,
    MODE_RRCA     = 5'd16,
    MODE_RRA      = 5'd17,
    MODE_ADD16    = 5'd18,
    MODE_ADD_SP_E = 5'd19,
    MODE_INC16    = 5'd20,
    MODE_DEC16    = 5'd21
  } mode_e;

  localparam logic [3:0] DaaLowLimit  = 4'h9;
  localparam logic [7:0] DaaHighLimit = 8'h99;
  localparam logic [7:0] DaaLowCorr   = 8'h06;
  localparam logic [7:0] DaaHighCorr  = 8'h60;

  typedef struct packed {
    logic [4:0]  mode;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [15:0] wide_a;
    logic [15:0] wide_b;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic        writes_result;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
  } alu_out_t;

endpackage

`default_nettype wire

>>> src/alu8_core.sv
// ----------------------------------------------------------------------------
// alu8_core
// Combinational datapath: result and new flags for one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module alu8_core (
  input  alu8_pkg::alu_in_t  op_i,
  output alu8_pkg::alu_out_t res_o
);

  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [7:0]  corr;
  logic        daa_c;
  logic [7:0]  daa_r;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sext;
  logic [15:0] sp_sum;
  logic [4:0]  sp_lo5;
  logic [8:0]  sp_lo9;
  logic [7:0]  r8;

  always_comb begin
    cin = ((op_i.mode == alu8_pkg::MODE_ADC) || (op_i.mode == alu8_pkg::MODE_SBC))
          ? op_i.c : 1'b0;
    sum9 = {1'b0, op_i.acc} + {1'b0, op_i.operand} + {8'd0, cin};
    sum5 = {1'b0, op_i.acc[3:0]} + {1'b0, op_i.operand[3:0]} + {4'd0, cin};
    dif9 = {1'b0, op_i.acc} - {1'b0, op_i.operand} - {8'd0, cin};
    dif5 = {1'b0, op_i.acc[3:0]} - {1'b0, op_i.operand[3:0]} - {4'd0, cin};

    // Decimal adjust: the correction depends on the direction of the last operation.
    corr  = '0;
    daa_c = 1'b0;
    if (op_i.h || (!op_i.n && (op_i.acc[3:0] > alu8_pkg::DaaLowLimit))) begin
      corr = corr | alu8_pkg::DaaLowCorr;
    end
    if (op_i.c || (!op_i.n && (op_i.acc > alu8_pkg::DaaHighLimit))) begin
      corr  = corr | alu8_pkg::DaaHighCorr;
      daa_c = 1'b1;
    end
    daa_r = op_i.n ? (op_i.acc - corr) : (op_i.acc + corr);

    sum17  = {1'b0, op_i.wide_a} + {1'b0, op_i.wide_b};
    sum13  = {1'b0, op_i.wide_a[11:0]} + {1'b0, op_i.wide_b[11:0]};
    sext   = {{8{op_i.operand[7]}}, op_i.operand};
    sp_sum = op_i.wide_a + sext;
    sp_lo5 = {1'b0, op_i.wide_a[3:0]} + {1'b0, op_i.operand[3:0]};
    sp_lo9 = {1'b0, op_i.wide_a[7:0]} + {1'b0, op_i.operand};

    r8 = '0;
    res_o = '{result: '0, writes_result: 1'b0,
              z: op_i.z, n: op_i.n, h: op_i.h, c: op_i.c};

    case (alu8_pkg::mode_e'(op_i.mode))
      alu8_pkg::MODE_ADD, alu8_pkg::MODE_ADC: begin
        r8 = sum9[7:0];
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: 1'b0, h: sum5[4], c: sum9[8]};
      end
      alu8_pkg::MODE_SUB, alu8_pkg::MODE_SBC, alu8_pkg::MODE_CP: begin
        r8 = dif9[7:0];
        res_o = '{result: {8'd0, r8},
                  writes_result: (op_i.mode != alu8_pkg::MODE_CP),
                  z: (r8 == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
      end
      alu8_pkg::MODE_AND: begin
        r8 = op_i.acc & op_i.operand;
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: 1'b0, h: 1'b1, c: 1'b0};
      end
      alu8_pkg::MODE_XOR: begin
        r8 = op_i.acc ^ op_i.operand;
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8_pkg::MODE_OR: begin
        r8 = op_i.acc | op_i.operand;
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: 1'b0, h: 1'b0, c: 1'b0};
      end
      alu8_pkg::MODE_INC: begin
        r8 = op_i.operand + 8'd1;
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: 1'b0, h: (op_i.operand[3:0] == 4'hF), c: op_i.c};
      end
      alu8_pkg::MODE_DEC: begin
        r8 = op_i.operand - 8'd1;
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: 1'b1, h: (op_i.operand[3:0] == 4'h0), c: op_i.c};
      end
      alu8_pkg::MODE_DAA: begin
        r8 = daa_r;
        res_o = '{result: {8'd0, r8}, writes_result: 1'b1, z: (r8 == 8'd0),
                  n: op_i.n, h: 1'b0, c: daa_c};
      end
      alu8_pkg::MODE_CPL: begin
        res_o = '{result: {8'd0, ~op_i.acc}, writes_result: 1'b1, z: op_i.z,
                  n: 1'b1, h: 1'b1, c: op_i.c};
      end
      alu8_pkg::MODE_SCF: begin
        res_o = '{result: {8'd0, op_i.acc}, writes_result: 1'b0, z: op_i.z,
                  n: 1'b0, h: 1'b0, c: 1'b1};
      end
      alu8_pkg::MODE_CCF: begin
        res_o = '{result: {8'd0, op_i.acc}, writes_result: 1'b0, z: op_i.z,
                  n: 1'b0, h: 1'b0, c: ~op_i.c};
      end
      alu8_pkg::MODE_RLCA: begin
        res_o = '{result: {8'd0, op_i.acc[6:0], op_i.acc[7]}, writes_result: 1'b1,
                  z: 1'b0, n: 1'b0, h: 1'b0, c: op_i.acc[7]};
      end
      alu8_pkg::MODE_RLA: begin
        res_o = '{result: {8'd0, op_i.acc[6:0], op_i.c}, writes_result: 1'b1,
                  z: 1'b0, n: 1'b0, h: 1'b0, c: op_i.acc[7]};
      end
      alu8_pkg::MODE_RRCA: begin
        res_o = '{result: {8'd0, op_i.acc[0], op_i.acc[7:1]}, writes_result: 1'b1,
                  z: 1'b0, n: 1'b0, h: 1'b0, c: op_i.acc[0]};
      end
      alu8_pkg::MODE_RRA: begin
        res_o = '{result: {8'd0, op_i.c, op_i.acc[7:1]}, writes_result: 1'b1,
                  z: 1'b0, n: 1'b0, h: 1'b0, c: op_i.acc[0]};
      end
      alu8_pkg::MODE_ADD16: begin
        res_o = '{result: sum17[15:0], writes_result: 1'b1, z: op_i.z,
                  n: 1'b0, h: sum13[12], c: sum17[16]};
      end
      alu8_pkg::MODE_ADD_SP_E: begin
        res_o = '{result: sp_sum, writes_result: 1'b1, z: 1'b0,
                  n: 1'b0, h: sp_lo5[4], c: sp_lo9[8]};
      end
      alu8_pkg::MODE_INC16: begin
        res_o = '{result: op_i.wide_a + 16'd1, writes_result: 1'b1, z: op_i.z,
                  n: op_i.n, h: op_i.h, c: op_i.c};
      end
      alu8_pkg::MODE_DEC16: begin
        res_o = '{result: op_i.wide_a - 16'd1, writes_result: 1'b1, z: op_i.z,
                  n: op_i.n, h: op_i.h, c: op_i.c};
      end
      default: begin
        // Unused codes give a zero result that is not stored; flags pass through.
        res_o = '{result: '0, writes_result: 1'b0,
                  z: op_i.z, n: op_i.n, h: op_i.h, c: op_i.c};
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/eight_bit_alu_with_flags_top.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_top
// Eight-bit ALU with Z/N/H/C flags, decimal adjust and 16-bit add, increment and decrement.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register, passes through the combinational
// core and is offered from the result register; an output stall can hold it there.
// Throughput: one item per cycle while the output is not stalled; the input
// register feeds a single combinational pass into the result register.
// Reset clears both valid flags; the payload registers are not reset.
`default_nettype none

module eight_bit_alu_with_flags_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [4:0]  mode_i,
  input  wire logic [7:0]  acc_i,
  input  wire logic [7:0]  operand_i,
  input  wire logic [15:0] wide_a_i,
  input  wire logic [15:0] wide_b_i,
  input  wire logic        z_in_i,
  input  wire logic        n_in_i,
  input  wire logic        h_in_i,
  input  wire logic        c_in_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [15:0] result_o,
  output      logic        writes_result_o,
  output      logic        z_out_o,
  output      logic        n_out_o,
  output      logic        h_out_o,
  output      logic        c_out_o
);

  alu8_pkg::alu_in_t  op_q;
  logic               op_valid_q;
  alu8_pkg::alu_out_t res_d;
  alu8_pkg::alu_out_t res_q;
  logic               res_valid_q;
  logic               res_adv;
  logic               op_adv;

  // The result register can load whenever it is empty or being taken.
  assign res_adv    = !res_valid_q || !out_stall_i;
  assign op_adv     = !op_valid_q || res_adv;
  assign in_stall_o = !op_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (op_adv) begin
        op_valid_q <= in_valid_i;
      end
      if (res_adv) begin
        res_valid_q <= op_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_adv && in_valid_i) begin
      op_q <= '{mode: mode_i, acc: acc_i, operand: operand_i, wide_a: wide_a_i,
                wide_b: wide_b_i, z: z_in_i, n: n_in_i, h: h_in_i, c: c_in_i};
    end
    if (res_adv && op_valid_q) begin
      res_q <= res_d;
    end
  end

  alu8_core u_core (
    .op_i  (op_q),
    .res_o (res_d)
  );

  assign out_valid_o     = res_valid_q;
  assign result_o        = res_q.result;
  assign writes_result_o = res_q.writes_result;
  assign z_out_o         = res_q.z;
  assign n_out_o         = res_q.n;
  assign h_out_o         = res_q.h;
  assign c_out_o         = res_q.c;

endmodule

`default_nettype wire

>>> sim/alu8_flag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8_flag_checker
// Watches both channels of the eight-bit ALU, predicts each result item with
// its flags from the accepted input item and compares them in order.
// ----------------------------------------------------------------------------

module alu8_flag_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  alu8_pkg::alu_in_t in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [15:0]       result_i,
  input  logic              writes_result_i,
  input  logic              z_out_i,
  input  logic              n_out_i,
  input  logic              h_out_i,
  input  logic              c_out_i,
  output int                mismatch_count_o,
  output int                pending_o,
  output int                checked_o
);

  alu8_pkg::alu_out_t alu_out_queue[$];
  alu8_pkg::alu_out_t want;
  int                 mismatches = 0;
  int                 checked = 0;

  assign mismatch_count_o = mismatches;
  assign checked_o        = checked;

  function automatic alu8_pkg::alu_out_t predict_alu(alu8_pkg::alu_in_t it);
    alu8_pkg::alu_out_t o;
    logic               cin;
    logic [8:0]         byte_sum;
    logic [4:0]         nibble_sum;
    logic [7:0]         corr;
    logic [16:0]        word_sum;
    logic [12:0]        low12_sum;
    o.result        = 16'h0000;
    o.writes_result = 1'b1;
    o.z             = it.z;
    o.n             = it.n;
    o.h             = it.h;
    o.c             = it.c;
    cin = (it.mode == alu8_pkg::MODE_ADC || it.mode == alu8_pkg::MODE_SBC) ? it.c : 1'b0;
    case (it.mode)
      alu8_pkg::MODE_ADD, alu8_pkg::MODE_ADC: begin
        byte_sum   = {1'b0, it.acc} + {1'b0, it.operand} + {8'd0, cin};
        nibble_sum = {1'b0, it.acc[3:0]} + {1'b0, it.operand[3:0]} + {4'd0, cin};
        o.result   = {8'h00, byte_sum[7:0]};
        o.z        = (byte_sum[7:0] == 8'h00);
        o.n        = 1'b0;
        o.h        = nibble_sum[4];
        o.c        = byte_sum[8];
      end
      alu8_pkg::MODE_SUB, alu8_pkg::MODE_SBC, alu8_pkg::MODE_CP: begin
        // A negative difference shows up as the extra top bit, i.e. a borrow.
        byte_sum        = {1'b0, it.acc} - {1'b0, it.operand} - {8'd0, cin};
        nibble_sum      = {1'b0, it.acc[3:0]} - {1'b0, it.operand[3:0]} - {4'd0, cin};
        o.result        = {8'h00, byte_sum[7:0]};
        o.writes_result = (it.mode != alu8_pkg::MODE_CP);
        o.z             = (byte_sum[7:0] == 8'h00);
        o.n             = 1'b1;
        o.h             = nibble_sum[4];
        o.c             = byte_sum[8];
      end
      alu8_pkg::MODE_AND, alu8_pkg::MODE_XOR, alu8_pkg::MODE_OR: begin
        if (it.mode == alu8_pkg::MODE_AND) begin
          o.result = {8'h00, it.acc & it.operand};
        end else if (it.mode == alu8_pkg::MODE_XOR) begin
          o.result = {8'h00, it.acc ^ it.operand};
        end else begin
          o.result = {8'h00, it.acc | it.operand};
        end
        o.z = (o.result[7:0] == 8'h00);
        o.n = 1'b0;
        o.h = (it.mode == alu8_pkg::MODE_AND);
        o.c = 1'b0;
      end
      alu8_pkg::MODE_INC: begin
        o.result = {8'h00, it.operand + 8'h01};
        o.z      = (o.result[7:0] == 8'h00);
        o.n      = 1'b0;
        o.h      = (it.operand[3:0] == 4'hF);
      end
      alu8_pkg::MODE_DEC: begin
        o.result = {8'h00, it.operand - 8'h01};
        o.z      = (o.result[7:0] == 8'h00);
        o.n      = 1'b1;
        o.h      = (it.operand[3:0] == 4'h0);
      end
      alu8_pkg::MODE_DAA: begin
        corr = 8'h00;
        o.c  = 1'b0;
        if (it.h || (!it.n && it.acc[3:0] > alu8_pkg::DaaLowLimit)) begin
          corr = corr | alu8_pkg::DaaLowCorr;
        end
        if (it.c || (!it.n && it.acc > alu8_pkg::DaaHighLimit)) begin
          corr = corr | alu8_pkg::DaaHighCorr;
          o.c  = 1'b1;
        end
        o.result = {8'h00, it.n ? it.acc - corr : it.acc + corr};
        o.z      = (o.result[7:0] == 8'h00);
        o.h      = 1'b0;
      end
      alu8_pkg::MODE_CPL: begin
        o.result = {8'h00, ~it.acc};
        o.n      = 1'b1;
        o.h      = 1'b1;
      end
      alu8_pkg::MODE_SCF, alu8_pkg::MODE_CCF: begin
        o.result        = {8'h00, it.acc};
        o.writes_result = 1'b0;
        o.n             = 1'b0;
        o.h             = 1'b0;
        o.c             = (it.mode == alu8_pkg::MODE_SCF) ? 1'b1 : ~it.c;
      end
      alu8_pkg::MODE_RLCA, alu8_pkg::MODE_RLA, alu8_pkg::MODE_RRCA,
      alu8_pkg::MODE_RRA: begin
        case (it.mode)
          alu8_pkg::MODE_RLCA: o.result = {8'h00, it.acc[6:0], it.acc[7]};
          alu8_pkg::MODE_RLA:  o.result = {8'h00, it.acc[6:0], it.c};
          alu8_pkg::MODE_RRCA: o.result = {8'h00, it.acc[0], it.acc[7:1]};
          default:             o.result = {8'h00, it.c, it.acc[7:1]};
        endcase
        o.z = 1'b0;
        o.n = 1'b0;
        o.h = 1'b0;
        o.c = (it.mode == alu8_pkg::MODE_RLCA || it.mode == alu8_pkg::MODE_RLA)
              ? it.acc[7] : it.acc[0];
      end
      alu8_pkg::MODE_ADD16: begin
        word_sum  = {1'b0, it.wide_a} + {1'b0, it.wide_b};
        low12_sum = {1'b0, it.wide_a[11:0]} + {1'b0, it.wide_b[11:0]};
        o.result  = word_sum[15:0];
        o.n       = 1'b0;
        o.h       = low12_sum[12];
        o.c       = word_sum[16];
      end
      alu8_pkg::MODE_ADD_SP_E: begin
        // The offset is signed for the sum, but the flags use unsigned low-byte carries.
        nibble_sum = {1'b0, it.wide_a[3:0]} + {1'b0, it.operand[3:0]};
        byte_sum   = {1'b0, it.wide_a[7:0]} + {1'b0, it.operand};
        o.result   = it.wide_a + {{8{it.operand[7]}}, it.operand};
        o.z        = 1'b0;
        o.n        = 1'b0;
        o.h        = nibble_sum[4];
        o.c        = byte_sum[8];
      end
      alu8_pkg::MODE_INC16: o.result = it.wide_a + 16'h0001;
      alu8_pkg::MODE_DEC16: o.result = it.wide_a - 16'h0001;
      default:              o.writes_result = 1'b0;
    endcase
    return o;
  endfunction

  task automatic compare_field(string field, logic [15:0] exp_val, logic [15:0] got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", field, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alu_out_queue.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (alu_out_queue.size() == 0) begin
          mismatches++;
          $error("result item arrived with no prediction waiting");
        end else begin
          want = alu_out_queue.pop_front();
          compare_field("result", want.result, result_i);
          compare_field("writes_result", 16'(want.writes_result), 16'(writes_result_i));
          compare_field("z_out", 16'(want.z), 16'(z_out_i));
          compare_field("n_out", 16'(want.n), 16'(n_out_i));
          compare_field("h_out", 16'(want.h), 16'(h_out_i));
          compare_field("c_out", 16'(want.c), 16'(c_out_i));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        alu_out_queue.push_back(predict_alu(in_item_i));
      end
      pending_o <= alu_out_queue.size();
    end
  end

endmodule

>>> sim/tb_eight_bit_alu_with_flags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags_top
// Drives the eight-bit ALU with directed corner items for every operation and
// then with random items under random idling on both channels; a checker
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------

module tb_eight_bit_alu_with_flags_top;

  localparam int RandomItems = 850;
  localparam int TailItems   = 100;
  localparam int CycleLimit  = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  alu8_pkg::alu_in_t stim = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [15:0]       result;
  logic              writes_result;
  logic              z_out, n_out, h_out, c_out;

  int mismatch_count;
  int pending;
  int checked;
  int items_sent = 0;
  int cycle_count = 0;
  int idle_odds = 4;
  int stall_odds = 4;
  bit tail_phase = 1'b0;

  always #2 clk = ~clk;

  eight_bit_alu_with_flags_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (stim.mode),
    .acc_i          (stim.acc),
    .operand_i      (stim.operand),
    .wide_a_i       (stim.wide_a),
    .wide_b_i       (stim.wide_b),
    .z_in_i         (stim.z),
    .n_in_i         (stim.n),
    .h_in_i         (stim.h),
    .c_in_i         (stim.c),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_o       (result),
    .writes_result_o(writes_result),
    .z_out_o        (z_out),
    .n_out_o        (n_out),
    .h_out_o        (h_out),
    .c_out_o        (c_out)
  );

  alu8_flag_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_item_i       (stim),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .result_i        (result),
    .writes_result_i (writes_result),
    .z_out_i         (z_out),
    .n_out_i         (n_out),
    .h_out_i         (h_out),
    .c_out_i         (c_out),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Result stalls come in bursts; the odds are changed by the stimulus.
  initial begin
    forever begin
      @(posedge clk);
      if (!tail_phase && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic alu8_pkg::alu_in_t make_item(logic [4:0] mode, logic [7:0] acc_val,
                                                  logic [7:0] operand_val, logic [15:0] wa,
                                                  logic [15:0] wb, logic [3:0] znhc);
    alu8_pkg::alu_in_t it;
    it.mode    = mode;
    it.acc     = acc_val;
    it.operand = operand_val;
    it.wide_a  = wa;
    it.wide_b  = wb;
    {it.z, it.n, it.h, it.c} = znhc;
    return it;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners [8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h99, 8'h9A, 8'h01};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 7)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_word();
    logic [15:0] corners [8] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h1000,
                                 16'h8000, 16'h7FFF, 16'h00FF, 16'h0001};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 7)];
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Presents one item and returns at the edge where it is accepted.
  task automatic issue_item(alu8_pkg::alu_in_t it);
    if (!tail_phase && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    stim     <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    alu8_pkg::alu_in_t it;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_item(make_item(alu8_pkg::MODE_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, 4'b0000));
    issue_item(make_item(alu8_pkg::MODE_ADC, 8'h0F, 8'h00, 16'h0000, 16'h0000, 4'b0001));
    issue_item(make_item(alu8_pkg::MODE_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, 4'b0000));
    issue_item(make_item(alu8_pkg::MODE_SBC, 8'h10, 8'h0F, 16'h0000, 16'h0000, 4'b0001));
    issue_item(make_item(alu8_pkg::MODE_AND, 8'hF0, 8'h0F, 16'h0000, 16'h0000, 4'b0101));
    issue_item(make_item(alu8_pkg::MODE_XOR, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'b0011));
    issue_item(make_item(alu8_pkg::MODE_OR, 8'h00, 8'h80, 16'h0000, 16'h0000, 4'b1111));
    // A compare gives the difference but must not store it.
    issue_item(make_item(alu8_pkg::MODE_CP, 8'h3C, 8'h3C, 16'h0000, 16'h0000, 4'b0000));
    issue_item(make_item(alu8_pkg::MODE_INC, 8'h00, 8'hFF, 16'h0000, 16'h0000, 4'b0001));
    issue_item(make_item(alu8_pkg::MODE_DEC, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0000));
    issue_item(make_item(alu8_pkg::MODE_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, 4'b0000));
    issue_item(make_item(alu8_pkg::MODE_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0111));
    issue_item(make_item(alu8_pkg::MODE_CPL, 8'h55, 8'h00, 16'h0000, 16'h0000, 4'b1001));
    // The carry flag operations hand back the accumulator without storing it.
    issue_item(make_item(alu8_pkg::MODE_SCF, 8'hA5, 8'h00, 16'h0000, 16'h0000, 4'b1110));
    issue_item(make_item(alu8_pkg::MODE_CCF, 8'h5A, 8'h00, 16'h0000, 16'h0000, 4'b1001));
    issue_item(make_item(alu8_pkg::MODE_RLCA, 8'h80, 8'h00, 16'h0000, 16'h0000, 4'b1110));
    issue_item(make_item(alu8_pkg::MODE_RLA, 8'h7F, 8'h00, 16'h0000, 16'h0000, 4'b0001));
    issue_item(make_item(alu8_pkg::MODE_RRCA, 8'h01, 8'h00, 16'h0000, 16'h0000, 4'b0000));
    issue_item(make_item(alu8_pkg::MODE_RRA, 8'h01, 8'h00, 16'h0000, 16'h0000, 4'b0001));
    issue_item(make_item(alu8_pkg::MODE_ADD16, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 4'b1000));
    issue_item(make_item(alu8_pkg::MODE_ADD_SP_E, 8'h00, 8'h01, 16'h00FF, 16'h0000,
                         4'b1111));
    issue_item(make_item(alu8_pkg::MODE_ADD_SP_E, 8'h00, 8'hFF, 16'h0000, 16'h0000,
                         4'b0000));
    issue_item(make_item(alu8_pkg::MODE_INC16, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 4'b1111));
    issue_item(make_item(alu8_pkg::MODE_DEC16, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0000));
    // Unused operation codes pass every flag through and store nothing.
    issue_item(make_item(5'd22, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 4'b1010));
    issue_item(make_item(5'd31, 8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0101));

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 64 == 0) begin
        idle_odds  = (i % 192 == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 10);
        stall_odds = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 3 : 10);
      end
      tail_phase = (i >= RandomItems - TailItems);
      if ($urandom_range(0, 19) == 0) begin
        it.mode = 5'($urandom_range(22, 31));
      end else begin
        it.mode = 5'($urandom_range(0, 21));
      end
      it.acc     = pick_byte();
      it.operand = pick_byte();
      it.wide_a  = pick_word();
      it.wide_b  = pick_word();
      {it.z, it.n, it.h, it.c} = 4'($urandom_range(0, 15));
      issue_item(it);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items and checked %0d results, covering every operation code,",
             items_sent, checked);
    $display("the unused codes and random idling on both channels.");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/alu8_pkg.sv
src/alu8_core.sv
src/eight_bit_alu_with_flags_top.sv
sim/alu8_flag_checker.sv
sim/tb_eight_bit_alu_with_flags_top.sv
